[src/ilid_pkg.sv]
package ilid_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int DATA_W       = 64;
	localparam int CMD_W        = 3;
	localparam int IDX_W        = 6;
	localparam int NSZ_W        = 7;
	localparam int LEN_OUT_W    = 7;
	localparam int ST_W         = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_READ   = 3'd0,
		CMD_WRITE  = 3'd1,
		CMD_APPEND = 3'd2,
		CMD_INSERT = 3'd3,
		CMD_DELETE = 3'd4,
		CMD_RESIZE = 3'd5
	} cmd_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SHIFT,
		S_OUT
	} state_t;

	// what every cell does this cycle
	typedef enum logic [2:0] {
		COP_NONE,
		COP_WRITE,
		COP_APPEND,
		COP_INSERT,
		COP_DELETE,
		COP_GROW,
		COP_SNAP,
		COP_SHIFT
	} cell_op_t;

	typedef struct packed {
		cell_op_t            cop;
		logic [DATA_W-1:0]   value;
	} ctrl_t;

endpackage

[src/ilid_cell.sv]
module ilid_cell #(
	parameter int CMP_W = 7
) (
	input  logic                        clk,
	input  ilid_pkg::ctrl_t             ctrl,
	input  logic [CMP_W-1:0]            idx_e,
	input  logic [CMP_W-1:0]            len_e,
	input  logic [CMP_W-1:0]            pos,
	input  logic [ilid_pkg::DATA_W-1:0] left_word,
	input  logic [ilid_pkg::DATA_W-1:0] right_word,
	input  logic [ilid_pkg::DATA_W-1:0] right_rd,
	output logic [ilid_pkg::DATA_W-1:0] word,
	output logic [ilid_pkg::DATA_W-1:0] rd
);

	logic [ilid_pkg::DATA_W-1:0] word_q;
	logic [ilid_pkg::DATA_W-1:0] rd_q;

	// payload only, no reset
	always_ff @(posedge clk) begin
		case (ctrl.cop)
			ilid_pkg::COP_WRITE: begin
				if (pos == idx_e) word_q <= ctrl.value;
			end
			ilid_pkg::COP_APPEND: begin
				if (pos == len_e) word_q <= ctrl.value;
			end
			ilid_pkg::COP_INSERT: begin
				if (pos == idx_e) word_q <= ctrl.value;
				else if (pos > idx_e) word_q <= left_word;
			end
			ilid_pkg::COP_DELETE: begin
				if (pos >= idx_e) word_q <= right_word;
			end
			ilid_pkg::COP_GROW: begin
				if (pos >= len_e) word_q <= '0;
			end
			ilid_pkg::COP_SNAP: begin
				rd_q <= word_q;
			end
			ilid_pkg::COP_SHIFT: begin
				rd_q <= right_rd;
			end
			default: begin
			end
		endcase
	end

	assign word = word_q;
	assign rd   = rd_q;

endmodule

[src/indexed_list_with_insert_delete.sv]
// Sequence: accept in idle, an execute state, then an output state that waits
//   until the output register is free; a read with a nonzero index first walks
//   the snapshot down the read line to cell 0 in the shift state.
// One command in flight at a time: none is taken until the result is loaded.
// Reset (arst_n low): length zero, no result pending; element words are not
//   cleared and every slot below the length is written before it is read.
module indexed_list_with_insert_delete #(
	parameter int CAPACITY = ilid_pkg::CAPACITY_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [ilid_pkg::CMD_W-1:0]     command,
	input  logic [ilid_pkg::IDX_W-1:0]     index,
	input  logic [ilid_pkg::DATA_W-1:0]    value,
	input  logic [ilid_pkg::NSZ_W-1:0]     new_size,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [ilid_pkg::DATA_W-1:0]    read_value,
	output logic [ilid_pkg::LEN_OUT_W-1:0] length_now,
	output logic [ilid_pkg::ST_W-1:0]      status
);

	// length needs to hold CAPACITY itself; compares run at a width that also
	// covers the 7-bit new_size field
	localparam int LEN_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (LEN_W > ilid_pkg::NSZ_W) ? LEN_W : ilid_pkg::NSZ_W;
	localparam logic [CMP_W-1:0] CAP_E = CMP_W'(CAPACITY);

	ilid_pkg::state_t  state_q, state_n;

	// latched command
	ilid_pkg::cmd_t                cmd_q;
	logic [ilid_pkg::IDX_W-1:0]    idx_q;
	logic [ilid_pkg::DATA_W-1:0]   value_q;
	logic [ilid_pkg::NSZ_W-1:0]    nsz_q;

	logic [LEN_W-1:0]              len_q;
	ilid_pkg::status_t             stat_q;
	logic                          rd_ok_q;
	logic [ilid_pkg::IDX_W-1:0]    cnt_q;

	// output register, decouples the result from the next command
	logic                          out_valid_q;
	logic [ilid_pkg::DATA_W-1:0]   out_value_q;
	logic [ilid_pkg::LEN_OUT_W-1:0] out_len_q;
	ilid_pkg::status_t             out_stat_q;

	logic                          accept;
	logic                          load_out;
	logic [CMP_W-1:0]              idx_e, len_e, nsz_e;
	ilid_pkg::status_t             stat_c;
	logic [LEN_W-1:0]              len_c;
	ilid_pkg::cell_op_t            cop_c;
	ilid_pkg::ctrl_t               ctrl;

	logic [ilid_pkg::DATA_W-1:0]   word_w [CAPACITY];
	logic [ilid_pkg::DATA_W-1:0]   rd_w   [CAPACITY];

	assign accept = in_valid && in_ready;
	assign idx_e  = CMP_W'(idx_q);
	assign len_e  = CMP_W'(len_q);
	assign nsz_e  = CMP_W'(nsz_q);

	// range and capacity checks, new length and the cell operation
	always_comb begin
		stat_c = ilid_pkg::ST_OK;
		len_c  = len_q;
		cop_c  = ilid_pkg::COP_NONE;
		case (cmd_q)
			ilid_pkg::CMD_READ: begin
				if (idx_e < len_e) cop_c = ilid_pkg::COP_SNAP;
				else stat_c = ilid_pkg::ST_RANGE;
			end
			ilid_pkg::CMD_WRITE: begin
				if (idx_e < len_e) cop_c = ilid_pkg::COP_WRITE;
				else stat_c = ilid_pkg::ST_RANGE;
			end
			ilid_pkg::CMD_APPEND: begin
				if (len_e >= CAP_E) begin
					stat_c = ilid_pkg::ST_FULL;
				end else begin
					cop_c = ilid_pkg::COP_APPEND;
					len_c = len_q + LEN_W'(1);
				end
			end
			ilid_pkg::CMD_INSERT: begin
				// index check wins over full
				if (idx_e > len_e) begin
					stat_c = ilid_pkg::ST_RANGE;
				end else if (len_e >= CAP_E) begin
					stat_c = ilid_pkg::ST_FULL;
				end else begin
					cop_c = ilid_pkg::COP_INSERT;
					len_c = len_q + LEN_W'(1);
				end
			end
			ilid_pkg::CMD_DELETE: begin
				if (idx_e >= len_e) begin
					stat_c = ilid_pkg::ST_RANGE;
				end else begin
					cop_c = ilid_pkg::COP_DELETE;
					len_c = len_q - LEN_W'(1);
				end
			end
			ilid_pkg::CMD_RESIZE: begin
				// zeroing every slot at or above the old length covers growth;
				// slots beyond the new length are never read
				if (nsz_e > CAP_E) begin
					stat_c = ilid_pkg::ST_FULL;
				end else begin
					cop_c = ilid_pkg::COP_GROW;
					len_c = LEN_W'(nsz_q);
				end
			end
			default: begin
				// unused codes: no change, status ok
			end
		endcase
	end

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			ilid_pkg::S_IDLE: begin
				if (accept) state_n = ilid_pkg::S_EXEC;
			end
			ilid_pkg::S_EXEC: begin
				if (cop_c == ilid_pkg::COP_SNAP && idx_q != '0) state_n = ilid_pkg::S_SHIFT;
				else state_n = ilid_pkg::S_OUT;
			end
			ilid_pkg::S_SHIFT: begin
				if (cnt_q == ilid_pkg::IDX_W'(1)) state_n = ilid_pkg::S_OUT;
			end
			ilid_pkg::S_OUT: begin
				if (load_out) state_n = ilid_pkg::S_IDLE;
			end
			default: begin
				state_n = ilid_pkg::S_IDLE;
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready   = 1'b0;
		load_out   = 1'b0;
		ctrl.cop   = ilid_pkg::COP_NONE;
		ctrl.value = value_q;
		case (state_q)
			ilid_pkg::S_IDLE: begin
				in_ready = 1'b1;
			end
			ilid_pkg::S_EXEC: begin
				ctrl.cop = cop_c;
			end
			ilid_pkg::S_SHIFT: begin
				ctrl.cop = ilid_pkg::COP_SHIFT;
			end
			ilid_pkg::S_OUT: begin
				load_out = !out_valid_q || out_ready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ilid_pkg::S_IDLE;
			len_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == ilid_pkg::S_EXEC) len_q <= len_c;
			if (load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// command and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= ilid_pkg::cmd_t'(command);
			idx_q   <= index;
			value_q <= value;
			nsz_q   <= new_size;
		end
		if (state_q == ilid_pkg::S_EXEC) begin
			stat_q  <= stat_c;
			rd_ok_q <= (cop_c == ilid_pkg::COP_SNAP);
			cnt_q   <= idx_q;
		end else if (state_q == ilid_pkg::S_SHIFT) begin
			cnt_q <= cnt_q - ilid_pkg::IDX_W'(1);
		end
		if (load_out) begin
			out_value_q <= rd_ok_q ? rd_w[0] : '0;
			out_len_q   <= ilid_pkg::LEN_OUT_W'(len_q);
			out_stat_q  <= stat_q;
		end
	end

	// the chain: each cell sees its neighbours' words and the read line
	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		logic [ilid_pkg::DATA_W-1:0] left_w, right_w, right_rd_w;
		if (k == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = word_w[k-1];
		end
		if (k == CAPACITY - 1) begin : g_last
			assign right_w    = '0;
			assign right_rd_w = '0;
		end else begin : g_mid_r
			assign right_w    = word_w[k+1];
			assign right_rd_w = rd_w[k+1];
		end
		ilid_cell #(
			.CMP_W(CMP_W)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.idx_e     (idx_e),
			.len_e     (len_e),
			.pos       (CMP_W'(k)),
			.left_word (left_w),
			.right_word(right_w),
			.right_rd  (right_rd_w),
			.word      (word_w[k]),
			.rd        (rd_w[k])
		);
	end

	assign out_valid  = out_valid_q;
	assign read_value = out_value_q;
	assign length_now = out_len_q;
	assign status     = out_stat_q;

	// length never passes capacity
	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(len_q) <= CAP_E)
		else $error("length above capacity");

	// length only moves in the execute cycle
	a_len_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ilid_pkg::S_EXEC |=> $stable(len_q))
		else $error("length changed outside execute");

	// a failed command's beat carries a zero word
	a_rd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ilid_pkg::ST_OK |-> read_value == '0)
		else $error("read word on a failed command");

	// no new command while one is still in flight
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready && state_q == ilid_pkg::S_EXEC)
		else $error("command accepted while busy");

endmodule
